// ===== rtl/core/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared constants, codes and types of the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int QRS_FRAC_BITS = 16;
   localparam int QRS_WORD_BITS = 32;

   localparam int TOL_BITS = 16;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd66;

   localparam logic [1:0] COUNT_NONE = 2'd0;
   localparam logic [1:0] COUNT_ONE  = 2'd1;
   localparam logic [1:0] COUNT_TWO  = 2'd2;
   localparam logic [1:0] COUNT_INF  = 2'd3;

   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_INF,
      MODE_LIN,
      MODE_SQC,
      MODE_GEN
   } mode_type;

endpackage

// ===== rtl/core/quadratic_root_solver.sv =====
// Throughput: one request per cycle; busy stays low, and each request yields one
//    result, in request order. Depth is set by the bit-per-stage dividers and
//    the two-bits-per-stage square root pipeline.
// Reset: synchronous, clears all valid bits and loads the tolerance register with 66.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients,
// computed in a fully pipelined datapath with saturated results.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
   parameter int FRAC_BITS = qrs_pkg::QRS_FRAC_BITS,
   parameter int WORD_BITS = qrs_pkg::QRS_WORD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [WORD_BITS-1:0]         req_coef_a,
   input  logic signed [WORD_BITS-1:0]         req_coef_b,
   input  logic signed [WORD_BITS-1:0]         req_coef_c,
   input  logic                                csr_wr_en,
   input  logic        [qrs_pkg::TOL_BITS-1:0] csr_wr_data,
   output logic                                rsp_valid,
   output logic        [1:0]                   rsp_root_count,
   output logic signed [WORD_BITS-1:0]         rsp_root_first,
   output logic signed [WORD_BITS-1:0]         rsp_root_second,
   output logic                                rsp_saturated
);
   import qrs_pkg::*;

   localparam int W     = WORD_BITS;
   localparam int F     = FRAC_BITS;
   localparam int N1    = W + 2 * F;
   localparam int DW    = 2 * W + 1;
   localparam int SW0   = (DW > N1) ? DW : N1;
   localparam int SW    = SW0 + (SW0 % 2);
   localparam int SR    = SW / 2;
   localparam int TRW   = SR + 4;
   localparam int RMW   = SR + 2;
   localparam int MW    = W + 2;
   localparam int N2    = MW + F;
   localparam int CW    = N1;
   localparam int TOTAL = N1 + SR + 2 + N2;

   typedef struct packed {
      logic           valid;
      mode_type       mode;
      logic           na;
      logic           nb;
      logic           nc;
      logic [W-1:0]   ma;
      logic [W-1:0]   mb;
      logic [W-1:0]   mc;
   } front_type;

   typedef struct packed {
      front_type      f;
      logic [2*W-1:0] b2;
      logic [2*W-1:0] ac;
   } prod_type;

   typedef struct packed {
      logic           valid;
      mode_type       mode;
      logic           na;
      logic           nb;
      logic           nc;
      logic [W-1:0]   ma;
      logic [W-1:0]   mb;
      logic [N1-1:0]  d1_num;
      logic [W-1:0]   d1_rem;
      logic [W-1:0]   d1_den;
      logic [SW-1:0]  sq_x;
      logic [RMW-1:0] sq_rem;
      logic [SR-1:0]  sq_root;
      logic           neg1;
      logic           neg2;
      logic [N2-1:0]  d2_num1;
      logic [N2-1:0]  d2_num2;
      logic [W:0]     d2_rem1;
      logic [W:0]     d2_rem2;
   } work_type;

   typedef struct packed {
      logic         sat;
      logic [W-1:0] value;
   } clamp_type;

   typedef struct packed {
      logic          neg;
      logic [MW-1:0] mag;
   } smag_type;

   typedef struct packed {
      logic         valid;
      logic [1:0]   count;
      logic [W-1:0] first;
      logic [W-1:0] second;
      logic         sat;
   } rsp_type;

   function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
      return v[W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic near_zero(input logic [W-1:0] mag,
                                      input logic [TOL_BITS-1:0] tol);
      return (mag == '0) || (mag < W'(tol));
   endfunction

   function automatic smag_type sm_add(input logic sa, input logic [MW-1:0] ma,
                                       input logic sb, input logic [MW-1:0] mb);
      smag_type r;
      if (sa == sb) begin
         r.mag = ma + mb;
         r.neg = sa;
      end else if (ma >= mb) begin
         r.mag = ma - mb;
         r.neg = sa;
      end else begin
         r.mag = mb - ma;
         r.neg = sb;
      end
      if (r.mag == '0) begin
         r.neg = 1'b0;
      end
      return r;
   endfunction

   function automatic clamp_type clamp(input logic neg, input logic [CW-1:0] mag);
      clamp_type    r;
      logic [CW-1:0] lim;
      logic [W-1:0]  v;
      lim = neg ? CW'({1'b1, {(W-1){1'b0}}}) : CW'({1'b0, {(W-1){1'b1}}});
      if (mag > lim) begin
         v     = lim[W-1:0];
         r.sat = 1'b1;
      end else begin
         v     = mag[W-1:0];
         r.sat = 1'b0;
      end
      r.value = neg ? (W'(0) - v) : v;
      return r;
   endfunction

   logic [TOL_BITS-1:0] tol_ff, tol_in;
   front_type           s0_ff, s0_in;
   prod_type            s1_ff, s1_in;
   work_type            pipe_ff [0:TOTAL];
   work_type            pipe_in [0:TOTAL];
   rsp_type             out_ff, out_in;

   assign busy = 1'b0;

   always_comb begin
      tol_in = csr_wr_en ? csr_wr_data : tol_ff;
   end

   // decode
   always_comb begin
      logic nza, nzb, nzc;
      s0_in.valid = start && !busy;
      s0_in.na    = req_coef_a[W-1];
      s0_in.nb    = req_coef_b[W-1];
      s0_in.nc    = req_coef_c[W-1];
      s0_in.ma    = magnitude(req_coef_a);
      s0_in.mb    = magnitude(req_coef_b);
      s0_in.mc    = magnitude(req_coef_c);
      nza = near_zero(s0_in.ma, tol_ff);
      nzb = near_zero(s0_in.mb, tol_ff);
      nzc = near_zero(s0_in.mc, tol_ff);
      if (nza) begin
         if (nzb) begin
            s0_in.mode = nzc ? MODE_INF : MODE_NONE;
         end else begin
            s0_in.mode = MODE_LIN;
         end
      end else if (nzb) begin
         s0_in.mode = ((s0_in.mc == '0) || (s0_in.nc != s0_in.na)) ? MODE_SQC : MODE_NONE;
      end else begin
         s0_in.mode = MODE_GEN;
      end
   end

   // products
   always_comb begin
      s1_in.f  = s0_ff;
      s1_in.b2 = (2*W)'(s0_ff.mb) * (2*W)'(s0_ff.mb);
      s1_in.ac = (2*W)'(s0_ff.ma) * (2*W)'(s0_ff.mc);
   end

   // discriminant and divider setup
   always_comb begin
      logic [DW-1:0] b2e, ac4, d;
      logic          sub_case, ok;
      b2e      = DW'(s1_ff.b2);
      ac4      = DW'({s1_ff.ac, 2'b00});
      sub_case = (s1_ff.f.mc != '0) && (s1_ff.f.na == s1_ff.f.nc);
      ok       = !sub_case || (b2e >= ac4);
      d        = sub_case ? (b2e - ac4) : (b2e + ac4);
      pipe_in[0]       = '0;
      pipe_in[0].valid = s1_ff.f.valid;
      pipe_in[0].mode  = ((s1_ff.f.mode == MODE_GEN) && !ok) ? MODE_NONE : s1_ff.f.mode;
      pipe_in[0].na    = s1_ff.f.na;
      pipe_in[0].nb    = s1_ff.f.nb;
      pipe_in[0].nc    = s1_ff.f.nc;
      pipe_in[0].ma    = s1_ff.f.ma;
      pipe_in[0].mb    = s1_ff.f.mb;
      if (s1_ff.f.mode == MODE_LIN) begin
         pipe_in[0].d1_num = {{F{1'b0}}, s1_ff.f.mc, {F{1'b0}}};
         pipe_in[0].d1_den = s1_ff.f.mb;
      end else begin
         pipe_in[0].d1_num = {s1_ff.f.mc, {(2*F){1'b0}}};
         pipe_in[0].d1_den = s1_ff.f.ma;
      end
      pipe_in[0].sq_x = SW'(d);
   end

   for (genvar k = 0; k < TOTAL; k++) begin : g_stage
      if (k < N1) begin : g_div1
         logic [W:0] trial;
         always_comb begin
            pipe_in[k+1] = pipe_ff[k];
            trial = {pipe_ff[k].d1_rem, pipe_ff[k].d1_num[N1-1]};
            if (trial >= {1'b0, pipe_ff[k].d1_den}) begin
               pipe_in[k+1].d1_rem = W'(trial - {1'b0, pipe_ff[k].d1_den});
               pipe_in[k+1].d1_num = {pipe_ff[k].d1_num[N1-2:0], 1'b1};
            end else begin
               pipe_in[k+1].d1_rem = trial[W-1:0];
               pipe_in[k+1].d1_num = {pipe_ff[k].d1_num[N1-2:0], 1'b0};
            end
         end
      end else if (k == N1) begin : g_sq_load
         always_comb begin
            pipe_in[k+1] = pipe_ff[k];
            if (pipe_ff[k].mode == MODE_SQC) begin
               pipe_in[k+1].sq_x = SW'(pipe_ff[k].d1_num);
            end
            pipe_in[k+1].sq_rem  = '0;
            pipe_in[k+1].sq_root = '0;
         end
      end else if (k <= N1 + SR) begin : g_sqrt
         logic [TRW-1:0] trial, test;
         always_comb begin
            pipe_in[k+1] = pipe_ff[k];
            trial = {pipe_ff[k].sq_rem, pipe_ff[k].sq_x[SW-1:SW-2]};
            test  = TRW'({pipe_ff[k].sq_root, 2'b01});
            pipe_in[k+1].sq_x = {pipe_ff[k].sq_x[SW-3:0], 2'b00};
            if (trial >= test) begin
               pipe_in[k+1].sq_rem  = RMW'(trial - test);
               pipe_in[k+1].sq_root = {pipe_ff[k].sq_root[SR-2:0], 1'b1};
            end else begin
               pipe_in[k+1].sq_rem  = RMW'(trial);
               pipe_in[k+1].sq_root = {pipe_ff[k].sq_root[SR-2:0], 1'b0};
            end
         end
      end else if (k == N1 + SR + 1) begin : g_d2_load
         smag_type r1, r2;
         always_comb begin
            pipe_in[k+1] = pipe_ff[k];
            r1 = sm_add(!pipe_ff[k].nb, MW'(pipe_ff[k].mb), 1'b1, MW'(pipe_ff[k].sq_root));
            r2 = sm_add(!pipe_ff[k].nb, MW'(pipe_ff[k].mb), 1'b0, MW'(pipe_ff[k].sq_root));
            pipe_in[k+1].neg1    = r1.neg != pipe_ff[k].na;
            pipe_in[k+1].neg2    = r2.neg != pipe_ff[k].na;
            pipe_in[k+1].d2_num1 = {r1.mag, {F{1'b0}}};
            pipe_in[k+1].d2_num2 = {r2.mag, {F{1'b0}}};
            pipe_in[k+1].d2_rem1 = '0;
            pipe_in[k+1].d2_rem2 = '0;
         end
      end else begin : g_div2
         logic [W:0]   den;
         logic [W+1:0] trial1, trial2;
         always_comb begin
            pipe_in[k+1] = pipe_ff[k];
            den    = {pipe_ff[k].ma, 1'b0};
            trial1 = {pipe_ff[k].d2_rem1, pipe_ff[k].d2_num1[N2-1]};
            trial2 = {pipe_ff[k].d2_rem2, pipe_ff[k].d2_num2[N2-1]};
            if (trial1 >= {1'b0, den}) begin
               pipe_in[k+1].d2_rem1 = (W+1)'(trial1 - {1'b0, den});
               pipe_in[k+1].d2_num1 = {pipe_ff[k].d2_num1[N2-2:0], 1'b1};
            end else begin
               pipe_in[k+1].d2_rem1 = trial1[W:0];
               pipe_in[k+1].d2_num1 = {pipe_ff[k].d2_num1[N2-2:0], 1'b0};
            end
            if (trial2 >= {1'b0, den}) begin
               pipe_in[k+1].d2_rem2 = (W+1)'(trial2 - {1'b0, den});
               pipe_in[k+1].d2_num2 = {pipe_ff[k].d2_num2[N2-2:0], 1'b1};
            end else begin
               pipe_in[k+1].d2_rem2 = trial2[W:0];
               pipe_in[k+1].d2_num2 = {pipe_ff[k].d2_num2[N2-2:0], 1'b0};
            end
         end
      end
   end

   // clamp and select
   always_comb begin
      clamp_type c1, c2;
      c1 = '0;
      c2 = '0;
      out_in.valid = pipe_ff[TOTAL].valid;
      case (pipe_ff[TOTAL].mode)
         MODE_LIN: begin
            c1 = clamp((!pipe_ff[TOTAL].nc) != pipe_ff[TOTAL].nb, CW'(pipe_ff[TOTAL].d1_num));
            out_in.count = COUNT_ONE;
         end
         MODE_SQC: begin
            c1 = clamp(1'b0, CW'(pipe_ff[TOTAL].sq_root));
            c2 = clamp(1'b1, CW'(pipe_ff[TOTAL].sq_root));
            out_in.count = COUNT_TWO;
         end
         MODE_GEN: begin
            c1 = clamp(pipe_ff[TOTAL].neg1, CW'(pipe_ff[TOTAL].d2_num1));
            c2 = clamp(pipe_ff[TOTAL].neg2, CW'(pipe_ff[TOTAL].d2_num2));
            out_in.count = COUNT_TWO;
         end
         MODE_INF: begin
            out_in.count = COUNT_INF;
         end
         default: begin
            out_in.count = COUNT_NONE;
         end
      endcase
      out_in.first  = c1.value;
      out_in.second = c2.value;
      out_in.sat    = c1.sat || c2.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff       <= TOL_RESET;
         s0_ff.valid  <= 1'b0;
         s1_ff.f.valid <= 1'b0;
         for (int i = 0; i <= TOTAL; i++) begin
            pipe_ff[i].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else begin
         tol_ff  <= tol_in;
         s0_ff   <= s0_in;
         s1_ff   <= s1_in;
         pipe_ff <= pipe_in;
         out_ff  <= out_in;
      end
   end

   assign rsp_valid       = out_ff.valid;
   assign rsp_root_count  = out_ff.count;
   assign rsp_root_first  = out_ff.first;
   assign rsp_root_second = out_ff.second;
   assign rsp_saturated   = out_ff.sat;

endmodule

// ===== rtl/core/qrs_checker.sv =====
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks of the quadratic root solver, bound to the top level.
// ----------------------------------------------------------------------------
module qrs_checker #(
   parameter int WORD_BITS = qrs_pkg::QRS_WORD_BITS
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic [1:0]           rsp_root_count,
   input logic [WORD_BITS-1:0] rsp_root_first,
   input logic [WORD_BITS-1:0] rsp_root_second,
   input logic                 rsp_saturated
);
   import qrs_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_count == COUNT_NONE) |->
         (rsp_root_first == '0) && (rsp_root_second == '0) && !rsp_saturated)
      else $error("no-root result carries data");

   a_inf_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_count == COUNT_INF) |->
         (rsp_root_first == '0) && (rsp_root_second == '0) && !rsp_saturated)
      else $error("infinite-root result carries data");

   a_one_second: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_root_count == COUNT_ONE) |-> (rsp_root_second == '0))
      else $error("single-root result has a second root");

endmodule

bind quadratic_root_solver qrs_checker #(.WORD_BITS(WORD_BITS)) u_qrs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_root_count  (rsp_root_count),
   .rsp_root_first  (rsp_root_first),
   .rsp_root_second (rsp_root_second),
   .rsp_saturated   (rsp_saturated)
);

// ===== tb/quadratic_root_solver_tb.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb
// Drives coefficient requests into the solver with random gaps, predicts the
// root count, the roots and the saturation flag of each request with an exact
// integer model, and compares every response in order. The tolerance register
// is rewritten between phases, including both ends of its range.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;
   import qrs_pkg::*;

   localparam int FB = QRS_FRAC_BITS;
   localparam int WB = QRS_WORD_BITS;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [1:0]    count;
      logic [WB-1:0] first;
      logic [WB-1:0] second;
      logic          sat;
   } roots_type;

   logic clock, reset, start, busy, csr_wr_en;
   logic signed [WB-1:0] req_coef_a, req_coef_b, req_coef_c;
   logic [TOL_BITS-1:0] csr_wr_data;
   logic rsp_valid, rsp_saturated;
   logic [1:0] rsp_root_count;
   logic signed [WB-1:0] rsp_root_first, rsp_root_second;

   roots_type expected_roots[$];
   logic [TOL_BITS-1:0] tolerance;
   int mismatches = 0;
   int cycles = 0;
   bit no_gaps = 0;

   quadratic_root_solver dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coef_a(req_coef_a), .req_coef_b(req_coef_b), .req_coef_c(req_coef_c),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_root_count(rsp_root_count),
      .rsp_root_first(rsp_root_first), .rsp_root_second(rsp_root_second),
      .rsp_saturated(rsp_saturated)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] isqrt_floor(input logic [127:0] x);
      logic [63:0] res;
      logic [63:0] cand;
      res = 0;
      for (int i = 63; i >= 0; i--) begin
         cand = res | (64'd1 << i);
         if ({64'd0, cand} * {64'd0, cand} <= x) res = cand;
      end
      return res;
   endfunction

   // {sat, value}
   function automatic logic [WB:0] clamp_root(input logic neg, input logic [127:0] mag);
      logic [127:0] lim;
      logic [WB-1:0] v;
      logic sat;
      lim = neg ? (128'd1 << (WB-1)) : ((128'd1 << (WB-1)) - 1);
      sat = mag > lim;
      v = sat ? lim[WB-1:0] : mag[WB-1:0];
      return {sat, neg ? -v : v};
   endfunction

   // {sign, magnitude}
   function automatic logic [64:0] signed_sum(input logic sa, input logic [63:0] ma,
                                              input logic sb, input logic [63:0] mb);
      logic s;
      logic [63:0] m;
      if (sa == sb) begin
         m = ma + mb; s = sa;
      end else if (ma >= mb) begin
         m = ma - mb; s = sa;
      end else begin
         m = mb - ma; s = sb;
      end
      if (m == 0) s = 0;
      return {s, m};
   endfunction

   function automatic logic is_small(input logic [63:0] m);
      return m == 0 || m < tolerance;
   endfunction

   function automatic roots_type solve_roots(input logic [WB-1:0] a, input logic [WB-1:0] b,
                                             input logic [WB-1:0] c);
      roots_type r;
      logic na, nb, nc, ok;
      logic [63:0] ma, mb, mc, s;
      logic [127:0] b2, ac4, d, q;
      logic [WB:0] c1, c2;
      logic [64:0] t1, t2;
      r = '0;
      na = a[WB-1]; nb = b[WB-1]; nc = c[WB-1];
      ma = 64'(na ? WB'(~a + 1'b1) : a);
      mb = 64'(nb ? WB'(~b + 1'b1) : b);
      mc = 64'(nc ? WB'(~c + 1'b1) : c);
      if (is_small(ma)) begin
         if (is_small(mb)) begin
            r.count = is_small(mc) ? COUNT_INF : COUNT_NONE;
         end else begin
            q = ({64'd0, mc} << FB) / {64'd0, mb};
            c1 = clamp_root(nc == nb, q);
            r.first = c1[WB-1:0]; r.sat = c1[WB];
            r.count = COUNT_ONE;
         end
      end else if (is_small(mb)) begin
         if (mc == 0 || nc != na) begin
            q = ({64'd0, mc} << (2*FB)) / {64'd0, ma};
            s = isqrt_floor(q);
            c1 = clamp_root(1'b0, {64'd0, s});
            c2 = clamp_root(1'b1, {64'd0, s});
            r.first = c1[WB-1:0]; r.second = c2[WB-1:0]; r.sat = c1[WB] | c2[WB];
            r.count = COUNT_TWO;
         end
      end else begin
         b2 = {64'd0, mb} * {64'd0, mb};
         ac4 = ({64'd0, ma} * {64'd0, mc}) << 2;
         ok = 1;
         if (mc != 0 && na == nc) begin
            if (b2 < ac4) ok = 0;
            d = b2 - ac4;
         end else begin
            d = b2 + ac4;
         end
         if (ok) begin
            s = isqrt_floor(d);
            t1 = signed_sum(!nb, mb, 1'b1, s);
            t2 = signed_sum(!nb, mb, 1'b0, s);
            c1 = clamp_root(t1[64] != na, ({64'd0, t1[63:0]} << FB) / {64'd0, 2*ma});
            c2 = clamp_root(t2[64] != na, ({64'd0, t2[63:0]} << FB) / {64'd0, 2*ma});
            r.first = c1[WB-1:0]; r.second = c2[WB-1:0]; r.sat = c1[WB] | c2[WB];
            r.count = COUNT_TWO;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      roots_type exp_r, got;
      cycles <= cycles + 1;
      if (!reset) begin
         if (csr_wr_en) tolerance = csr_wr_data;
         if (start && !busy)
            expected_roots.push_back(solve_roots(req_coef_a, req_coef_b, req_coef_c));
         if (rsp_valid) begin
            got = '{rsp_root_count, rsp_root_first, rsp_root_second, rsp_saturated};
            if (expected_roots.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
               exp_r = expected_roots.pop_front();
               if (got !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected count %0d first %h second %h sat %b, got count %0d first %h second %h sat %b",
                        exp_r.count, exp_r.first, exp_r.second, exp_r.sat,
                        got.count, got.first, got.second, got.sat);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("quadratic_root_solver_tb failed");
         $finish;
      end
   end

   task automatic idle_gap();
      int p, n;
      p = $urandom_range(0, 99);
      n = no_gaps ? 0 : (p < 60 ? 0 : (p < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_request(input logic [WB-1:0] a, input logic [WB-1:0] b,
                               input logic [WB-1:0] c);
      start <= 1;
      req_coef_a <= a; req_coef_b <= b; req_coef_c <= c;
      do @(posedge clock); while (busy);
      idle_gap();
   endtask

   task automatic write_tolerance(input logic [TOL_BITS-1:0] value);
      start <= 0;
      @(posedge clock);
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic logic [WB-1:0] q16(input int v);
      return WB'(v <<< FB);
   endfunction

   function automatic logic [WB-1:0] near_zero_value();
      logic [WB-1:0] m;
      m = tolerance == 0 ? 0 : $urandom_range(0, tolerance - 1);
      return $urandom_range(0, 1) ? -m : m;
   endfunction

   function automatic logic [WB-1:0] pick_value();
      int p;
      p = $urandom_range(0, 9);
      if (p < 3) return $urandom;
      if (p < 5) return near_zero_value();
      if (p < 8) return WB'($signed($urandom_range(0, 32'h000FFFFF)) - 32'sh00080000);
      if (p < 9) return $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
      return 0;
   endfunction

   task automatic test_directed();
      send_request(0, 0, 0);
      send_request(0, 0, q16(1));
      send_request(0, q16(2), q16(-4));
      send_request(0, 100, 32'h7FFFFFFF);
      send_request(0, 100, 32'h80000000);
      send_request(q16(1), 0, 0);
      send_request(q16(1), 0, q16(-4));
      send_request(q16(1), 0, q16(4));
      send_request(q16(1), q16(-3), q16(2));
      send_request(q16(1), q16(1), q16(1));
      send_request(32'h80000000, 32'h80000000, 32'h80000000);
      send_request(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_request(32'h80000000, 32'h7FFFFFFF, 0);
      send_request(100, 0, 32'h7FFFFFFF);
      send_request(100, 32'h80000000, 32'h80000000);
      send_request(65, q16(1), q16(1));
      send_request(-65, 65, 65);
      send_request(66, -66, 66);
      send_request(q16(-2), q16(8), 32'hFFFFFFFF);
   endtask

   task automatic test_tolerance_extremes();
      write_tolerance(0);
      send_request(0, 0, 0);
      send_request(1, 0, 1);
      send_request(1, 1, 1);
      send_request(0, 1, 32'h7FFFFFFF);
      send_request(-1, 0, 0);
      write_tolerance(16'hFFFF);
      send_request(16'hFFFF, 16'hFFFE, 1);
      send_request(32'h00010000, 32'hFFFF0001, q16(3));
      send_request(32'hFFFF0000, 0, q16(9));
      send_request(-16'sd65535, 32'h00010000, 5);
   endtask

   task automatic test_random(input int n);
      int kind;
      logic [WB-1:0] a, b, c;
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) no_gaps = $urandom_range(0, 3) == 0;
         kind = $urandom_range(0, 9);
         a = pick_value(); b = pick_value(); c = pick_value();
         case (kind)
            0: a = near_zero_value();
            1: begin
               a = near_zero_value(); b = near_zero_value();
            end
            2: b = near_zero_value();
            3: begin
               b = near_zero_value(); c = 0;
            end
            4: begin
               b = WB'($signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
               c = -a;
            end
            default: ;
         endcase
         send_request(a, b, c);
      end
      no_gaps = 0;
   endtask

   initial begin
      reset = 1; start = 0; csr_wr_en = 0; csr_wr_data = 0;
      req_coef_a = 0; req_coef_b = 0; req_coef_c = 0;
      tolerance = TOL_RESET;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_tolerance_extremes();
      write_tolerance(TOL_RESET);
      test_random(600);
      write_tolerance(16'hFFFF);
      test_random(350);
      write_tolerance(0);
      test_random(350);
      write_tolerance($urandom_range(1, 16'hFFFE));
      test_random(400);
      start <= 0;
      @(posedge clock);
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("quadratic_root_solver_tb passed");
      else $display("quadratic_root_solver_tb failed");
      $finish;
   end
endmodule

// ===== quadratic_root_solver.f =====
rtl/core/qrs_pkg.sv
rtl/core/quadratic_root_solver.sv
rtl/core/qrs_checker.sv
tb/quadratic_root_solver_tb.sv
